// File: rtl/text_window_terminal_writer_assert.svh
// assertion macros for the text window terminal writer
// used by the top level only; the macros expect clk_i and rst_ni in scope
`ifndef TEXT_WINDOW_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_WINDOW_TERMINAL_WRITER_ASSERT_SVH

`ifndef SYNTH
`define TWTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TWTW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TWTW_ASSERT(lbl, prop, msg)
`define TWTW_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/twtw_pkg.sv
// shared types and constants for the text window terminal writer
// no dependencies
package twtw_pkg;

  localparam int DEF_PAGE_COLUMNS = 32;
  localparam int DEF_PAGE_LINES   = 16;

  // control characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [2:0] VT_LINES = 3'd6;

  // register reset values
  localparam logic [4:0] RST_WIN_LEFT   = 5'd0;
  localparam logic [3:0] RST_WIN_TOP    = 4'd0;
  localparam logic [5:0] RST_WIN_WIDTH  = 6'd32;
  localparam logic [4:0] RST_WIN_HEIGHT = 5'd16;
  localparam logic [5:0] RST_TAB_SIZE   = 6'd8;
  localparam logic [7:0] RST_FONT_OFS   = 8'd32;

  typedef enum logic [2:0] {
    OP_WRITE_CHAR = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_CLEAR_WIN  = 3'd2,
    OP_CLEAR_EOL  = 3'd3,
    OP_READ_CELL  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CFG_WIN_LEFT   = 3'd0,
    CFG_WIN_TOP    = 3'd1,
    CFG_WIN_WIDTH  = 3'd2,
    CFG_WIN_HEIGHT = 3'd3,
    CFG_TAB_SIZE   = 3'd4,
    CFG_FONT_OFS   = 3'd5
  } cfg_idx_e;

  // effective window after clamping
  typedef struct packed {
    logic [4:0] wl;
    logic [3:0] wt;
    logic [5:0] ww;
    logic [4:0] wh;
    logic [5:0] ts;
    logic [7:0] fo;
  } win_t;

  // memory write side
  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
  } mem_wr_t;

endpackage

// File: rtl/twtw_page.sv
// page cell memory, one port, registered read data
// depends on twtw_pkg for the write request struct
module twtw_page #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic              clk_i,
  input  twtw_pkg::mem_wr_t wr_i,
  input  logic [AW-1:0]     addr_i,
  output logic [7:0]        rdata_o
);
  import twtw_pkg::*;

  logic [7:0] mem [DEPTH];

  // write or read at one address
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[addr_i] <= wr_i.wdata;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/twtw_seq.sv
// sequencer: cursor state, character handling and cell sweeps over the page port
// depends on twtw_pkg
module twtw_seq #(
  parameter int PAGE_COLUMNS = twtw_pkg::DEF_PAGE_COLUMNS,
  parameter int PAGE_LINES   = twtw_pkg::DEF_PAGE_LINES,
  parameter int AW           = $clog2(PAGE_COLUMNS * PAGE_LINES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  twtw_pkg::win_t     win_i,
  input  logic               home_i,
  input  logic               start_i,
  input  logic [2:0]         op_i,
  input  logic [7:0]         char_code_i,
  input  logic [5:0]         pos_x_i,
  input  logic [4:0]         pos_y_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output logic [5:0]         cursor_col_o,
  output logic [4:0]         cursor_row_o,
  output logic               pause_flag_o,
  output logic [7:0]         read_data_o,
  output twtw_pkg::mem_wr_t  wr_o,
  output logic [AW-1:0]      addr_o,
  input  logic [7:0]         rdata_i
);
  import twtw_pkg::*;

  localparam int DEPTH = PAGE_COLUMNS * PAGE_LINES;

  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_WRAP   = 13'b0000000000100,
    S_ACT    = 13'b0000000001000,
    S_TAB    = 13'b0000000010000,
    S_VT     = 13'b0000000100000,
    S_FIN    = 13'b0000001000000,
    S_SCR_RD = 13'b0000010000000,
    S_SCR_WR = 13'b0000100000000,
    S_CLR    = 13'b0001000000000,
    S_RD     = 13'b0010000000000,
    S_RD2    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  state_e        state_q, state_d, ret_q, ret_d, scroll_ret;
  logic [5:0]    cx_q, cx_d;
  logic [4:0]    cy_q, cy_d;
  logic          pause_q, pause_d;
  logic [7:0]    ch_q, ch_d;
  logic [5:0]    px_q, px_d;
  logic [4:0]    py_q, py_d;
  logic          tab_act_q, tab_act_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [6:0]    m_q, m_d;
  logic [2:0]    vcnt_q, vcnt_d;
  logic [5:0]    ix_q, ix_d;
  logic [4:0]    iy_q, iy_d, ilast_q, ilast_d;
  logic [AW-1:0] initc_q, initc_d;
  logic          res_valid_q;
  logic [5:0]    res_col_q;
  logic [4:0]    res_row_q;
  logic          res_pause_q;
  logic [7:0]    res_rd_q;

  logic          emit, do_scroll, we;
  logic [7:0]    wdata, rd_val;
  logic [5:0]    sel_col, ww_m1;
  logic [4:0]    sel_row, wh_m1;
  logic [5:0]    y_w, y_n;
  logic [5:0]    bx;
  logic [4:0]    by;
  logic [5:0]    row_sum;
  logic [6:0]    col_sum;

  assign ww_m1 = win_i.ww - 6'd1;
  assign wh_m1 = win_i.wh - 5'd1;

  // next state logic
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    scroll_ret = S_ACT;
    cx_d       = cx_q;
    cy_d       = cy_q;
    pause_d    = pause_q;
    ch_d       = ch_q;
    px_d       = px_q;
    py_d       = py_q;
    tab_act_d  = tab_act_q;
    cnt_d      = cnt_q;
    m_d        = m_q;
    vcnt_d     = vcnt_q;
    ix_d       = ix_q;
    iy_d       = iy_q;
    ilast_d    = ilast_q;
    initc_d    = initc_q;
    emit       = 1'b0;
    do_scroll  = 1'b0;
    we         = 1'b0;
    wdata      = 8'd0;
    rd_val     = 8'd0;
    sel_col    = cx_q;
    sel_row    = cy_q;
    y_w        = {1'b0, cy_q};
    y_n        = {1'b0, cy_q} + 6'd1;
    bx         = cx_q;
    by         = cy_q;

    case (state_q)
      // clear every page cell after reset
      S_INIT: begin
        we = 1'b1;
        if (initc_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          initc_d = initc_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (home_i) begin
          cx_d = 6'd0;
          cy_d = 5'd0;
        end
        if (start_i) begin
          px_d = pos_x_i;
          py_d = pos_y_i;
          case (op_e'(op_i))
            OP_WRITE_CHAR: begin
              ch_d      = char_code_i;
              tab_act_d = 1'b0;
              state_d   = S_WRAP;
            end
            OP_SET_CURSOR: begin
              cx_d = (pos_x_i > win_i.ww) ? win_i.ww : pos_x_i;
              cy_d = (pos_y_i > win_i.wh) ? win_i.wh : pos_y_i;
              emit = 1'b1;
            end
            OP_CLEAR_WIN: begin
              cx_d    = 6'd0;
              cy_d    = 5'd0;
              ix_d    = 6'd0;
              iy_d    = 5'd0;
              ilast_d = wh_m1;
              ret_d   = S_DONE;
              state_d = S_CLR;
            end
            OP_CLEAR_EOL: begin
              if (cy_q < win_i.wh && cx_q < win_i.ww) begin
                ix_d    = cx_q;
                iy_d    = cy_q;
                ilast_d = cy_q;
                ret_d   = S_DONE;
                state_d = S_CLR;
              end else begin
                emit = 1'b1;
              end
            end
            OP_READ_CELL: begin
              if (pos_x_i < win_i.ww && pos_y_i < win_i.wh) begin
                state_d = S_RD;
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end

      // auto-wrap, then scroll when past the last row
      S_WRAP: begin
        if (cx_q >= win_i.ww && ch_q != CH_LF && ch_q != CH_CR) begin
          cx_d = 6'd0;
          y_w  = {1'b0, cy_q} + 6'd1;
        end
        if (y_w >= {1'b0, win_i.wh}) begin
          do_scroll  = 1'b1;
          scroll_ret = S_ACT;
        end else begin
          cy_d    = y_w[4:0];
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        case (ch_q)
          CH_LF: begin
            cy_d = cy_q + 5'd1;
            if (cx_q >= ww_m1) cx_d = 6'd0;
            state_d = S_FIN;
          end
          CH_CR: begin
            cx_d    = 6'd0;
            state_d = S_FIN;
          end
          CH_TAB: begin
            m_d     = {1'b0, win_i.ts};
            state_d = S_TAB;
          end
          CH_BS: begin
            if (cx_q != 6'd0) begin
              bx = cx_q - 6'd1;
            end else if (cy_q != 5'd0) begin
              bx = ww_m1;
              by = cy_q - 5'd1;
            end
            cx_d    = bx;
            cy_d    = by;
            sel_col = bx;
            sel_row = by;
            we      = (bx < win_i.ww) && (by < win_i.wh);
            state_d = S_FIN;
          end
          CH_VT: begin
            cx_d    = 6'd0;
            vcnt_d  = VT_LINES;
            state_d = S_VT;
          end
          default: begin
            we      = (cx_q < win_i.ww) && (cy_q < win_i.wh);
            wdata   = ch_q - win_i.fo;
            cx_d    = cx_q + 6'd1;
            state_d = S_FIN;
          end
        endcase
      end

      // next tab stop by repeated add of the tab size
      S_TAB: begin
        if (m_q <= {1'b0, cx_q}) begin
          m_d = m_q + {1'b0, win_i.ts};
        end else begin
          cnt_d     = 6'(m_q - {1'b0, cx_q});
          ch_d      = CH_SPACE;
          tab_act_d = 1'b1;
          state_d   = S_WRAP;
        end
      end

      // vertical tab, one line a step
      S_VT: begin
        if (vcnt_q == 3'd0) begin
          state_d = S_FIN;
        end else begin
          vcnt_d = vcnt_q - 3'd1;
          if (y_n >= {1'b0, wh_m1}) begin
            do_scroll  = 1'b1;
            scroll_ret = S_VT;
          end else begin
            cy_d = y_n[4:0];
          end
        end
      end

      // pause flag, and loop over tab spaces
      S_FIN: begin
        pause_d = (cx_q >= win_i.ww || ch_q == CH_LF) && (cy_q >= wh_m1);
        if (tab_act_q && cnt_q != 6'd1) begin
          cnt_d   = cnt_q - 6'd1;
          state_d = S_WRAP;
        end else begin
          tab_act_d = 1'b0;
          emit      = 1'b1;
          state_d   = S_IDLE;
        end
      end

      // scroll copy: read the row below
      S_SCR_RD: begin
        sel_col = ix_q;
        sel_row = iy_q + 5'd1;
        state_d = S_SCR_WR;
      end

      S_SCR_WR: begin
        sel_col = ix_q;
        sel_row = iy_q;
        we      = 1'b1;
        wdata   = rdata_i;
        if (ix_q >= ww_m1) begin
          ix_d = 6'd0;
          if (iy_q + 5'd1 >= wh_m1) begin
            iy_d    = wh_m1;
            ilast_d = wh_m1;
            state_d = S_CLR;
          end else begin
            iy_d    = iy_q + 5'd1;
            state_d = S_SCR_RD;
          end
        end else begin
          ix_d    = ix_q + 6'd1;
          state_d = S_SCR_RD;
        end
      end

      // clear a run of cells, row by row
      S_CLR: begin
        sel_col = ix_q;
        sel_row = iy_q;
        we      = 1'b1;
        if (ix_q >= ww_m1) begin
          if (iy_q >= ilast_q) begin
            state_d = ret_q;
          end else begin
            ix_d = 6'd0;
            iy_d = iy_q + 5'd1;
          end
        end else begin
          ix_d = ix_q + 6'd1;
        end
      end

      S_RD: begin
        sel_col = px_q;
        sel_row = py_q;
        state_d = S_RD2;
      end

      S_RD2: begin
        rd_val  = rdata_i;
        emit    = 1'b1;
        state_d = S_IDLE;
      end

      S_DONE: begin
        emit    = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // scroll entry: cursor to start of last row, copy rows, clear last row
    if (do_scroll) begin
      cx_d    = 6'd0;
      cy_d    = wh_m1;
      ix_d    = 6'd0;
      iy_d    = 5'd0;
      ilast_d = wh_m1;
      ret_d   = scroll_ret;
      state_d = (win_i.wh > 5'd1) ? S_SCR_RD : S_CLR;
    end
  end

  // page address from window-relative column and row
  assign row_sum = {2'b00, win_i.wt} + {1'b0, sel_row};
  assign col_sum = {2'b00, win_i.wl} + {1'b0, sel_col};
  assign addr_o  = (state_q == S_INIT) ? initc_q
                 : AW'(row_sum * PAGE_COLUMNS) + AW'(col_sum);
  assign wr_o.we    = we;
  assign wr_o.wdata = wdata;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_DONE;
      cx_q        <= 6'd0;
      cy_q        <= 5'd0;
      pause_q     <= 1'b0;
      tab_act_q   <= 1'b0;
      cnt_q       <= 6'd0;
      vcnt_q      <= 3'd0;
      ix_q        <= 6'd0;
      iy_q        <= 5'd0;
      ilast_q     <= 5'd0;
      initc_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      pause_q     <= pause_d;
      tab_act_q   <= tab_act_d;
      cnt_q       <= cnt_d;
      vcnt_q      <= vcnt_d;
      ix_q        <= ix_d;
      iy_q        <= iy_d;
      ilast_q     <= ilast_d;
      initc_q     <= initc_d;
      res_valid_q <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    px_q <= px_d;
    py_q <= py_d;
    m_q  <= m_d;
    if (emit) begin
      res_col_q   <= cx_d;
      res_row_q   <= cy_d;
      res_pause_q <= pause_d;
      res_rd_q    <= rd_val;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign cursor_col_o = res_col_q;
  assign cursor_row_o = res_row_q;
  assign pause_flag_o = res_pause_q;
  assign read_data_o  = res_rd_q;

endmodule

// File: rtl/text_window_terminal_writer.sv
// top level: configuration registers, window clamping, sequencer and page memory
// depends on twtw_pkg, twtw_seq, twtw_page and the assertion header
//
// A request is taken when start is high and busy is low; each request gives one
// result, shown on the result ports for a single cycle with result_valid_o, and
// the receiver cannot stall it. Cells go through one memory port, one cell per
// cycle for clears; a scroll copy reads each cell of the row below, then
// writes it. Set cursor and out-of-window reads answer in the cycle after they
// are taken; a cell read goes through S_RD and S_RD2, a printable character
// through S_WRAP, S_ACT and S_FIN. A scroll copies every row up and clears the
// last, a tab gives up to tab_size spaces each with possible scroll, a vertical
// tab up to six scrolls. After reset the block is busy while it clears the page.
// Configuration writes are always taken and must only occur while idle.
module text_window_terminal_writer #(
  parameter int PAGE_COLUMNS = twtw_pkg::DEF_PAGE_COLUMNS,
  parameter int PAGE_LINES   = twtw_pkg::DEF_PAGE_LINES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] pos_x_i,
  input  logic [4:0] pos_y_i,
  output logic       result_valid_o,
  output logic [5:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic       pause_flag_o,
  output logic [7:0] read_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import twtw_pkg::*;

  `include "text_window_terminal_writer_assert.svh"

  localparam int DEPTH = PAGE_COLUMNS * PAGE_LINES;
  localparam int AW    = $clog2(DEPTH);

  logic [4:0]    win_left_q;
  logic [3:0]    win_top_q;
  logic [5:0]    win_width_q;
  logic [4:0]    win_height_q;
  logic [5:0]    tab_size_q;
  logic [7:0]    font_ofs_q;
  logic          cfg_we, home;
  win_t          win;
  logic [5:0]    ww0;
  logic [4:0]    wh0;
  mem_wr_t       mem_wr;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= RST_WIN_LEFT;
      win_top_q    <= RST_WIN_TOP;
      win_width_q  <= RST_WIN_WIDTH;
      win_height_q <= RST_WIN_HEIGHT;
      tab_size_q   <= RST_TAB_SIZE;
      font_ofs_q   <= RST_FONT_OFS;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIN_LEFT:   win_left_q   <= cfg_data_i[4:0];
        CFG_WIN_TOP:    win_top_q    <= cfg_data_i[3:0];
        CFG_WIN_WIDTH:  win_width_q  <= cfg_data_i[5:0];
        CFG_WIN_HEIGHT: win_height_q <= cfg_data_i[4:0];
        CFG_TAB_SIZE:   tab_size_q   <= cfg_data_i[5:0];
        CFG_FONT_OFS:   font_ofs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window register writes home the cursor
  assign home = cfg_we && (cfg_index_i == CFG_WIN_LEFT || cfg_index_i == CFG_WIN_TOP ||
                           cfg_index_i == CFG_WIN_WIDTH || cfg_index_i == CFG_WIN_HEIGHT);

  // clamp the window onto the page
  always_comb begin
    win.wl = (int'(win_left_q) > PAGE_COLUMNS - 2) ? 5'(PAGE_COLUMNS - 2) : win_left_q;
    win.wt = (int'(win_top_q) > PAGE_LINES - 2) ? 4'(PAGE_LINES - 2) : win_top_q;
    ww0    = (win_width_q == 6'd0) ? 6'd1 : win_width_q;
    wh0    = (win_height_q == 5'd0) ? 5'd1 : win_height_q;
    win.ww = (int'(ww0) > PAGE_COLUMNS - int'(win.wl)) ?
             6'(PAGE_COLUMNS - int'(win.wl)) : ww0;
    win.wh = (int'(wh0) > PAGE_LINES - int'(win.wt)) ?
             5'(PAGE_LINES - int'(win.wt)) : wh0;
    win.ts = (tab_size_q == 6'd0) ? 6'd1 : tab_size_q;
    win.fo = font_ofs_q;
  end

  twtw_seq #(
    .PAGE_COLUMNS (PAGE_COLUMNS),
    .PAGE_LINES   (PAGE_LINES),
    .AW           (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_i        (win),
    .home_i       (home),
    .start_i      (start),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .busy_o       (busy),
    .res_valid_o  (result_valid_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .pause_flag_o (pause_flag_o),
    .read_data_o  (read_data_o),
    .wr_o         (mem_wr),
    .addr_o       (mem_addr),
    .rdata_i      (mem_rdata)
  );

  twtw_page #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_page (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .addr_i  (mem_addr),
    .rdata_o (mem_rdata)
  );

  // a taken request either starts work or answers next cycle
  `TWTW_ASSERT_NEXT(a_start_progress, start && !busy, busy || result_valid_o, "request lost")
  // results are only shown while idle
  `TWTW_ASSERT(a_result_idle, result_valid_o |-> !busy, "result while busy")
  // work only begins on a request
  `TWTW_ASSERT(a_busy_cause, $rose(busy) |-> $past(start), "busy without request")

endmodule

// File: test/tb.sv
// self-checking bench for text_window_terminal_writer: directed table then random traffic
// depends on twtw_pkg and the rtl top level; holds its own model of the page and cursor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twtw_pkg::*;

  localparam int COLS = DEF_PAGE_COLUMNS;
  localparam int ROWS = DEF_PAGE_LINES;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int MAX_PRINTS = 40;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [5:0] col;
    logic [4:0] row;
    logic       pause;
    logic [7:0] rd;
  } cursor_rsp_t;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [5:0]  x;
    logic [4:0]  y;
    bit          typed;
    cursor_rsp_t rsp;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] op_i = '0;
  logic [7:0] char_code_i = '0;
  logic [5:0] pos_x_i = '0;
  logic [4:0] pos_y_i = '0;
  logic       result_valid_o;
  logic [5:0] cursor_col_o;
  logic [4:0] cursor_row_o;
  logic       pause_flag_o;
  logic [7:0] read_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  text_window_terminal_writer dut (.*);

  always #10 clk_i = ~clk_i;

  // model state: page, cursor and raw registers
  logic [7:0] page [COLS*ROWS];
  int unsigned cur_x, cur_y, pause_st;
  int unsigned r_left, r_top, r_width, r_height, r_tab, r_font;
  int unsigned wl, wt, ww, wh;

  cursor_rsp_t expected_q[$];
  int errors, prints, idle_cycles, n_items, n_results, n_cfg, n_reads, n_scrolls;
  int burst_left;

  task automatic report(string what, int got, int want);
    errors++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic void derive_window();
    wl = (r_left > COLS-2) ? COLS-2 : r_left;
    wt = (r_top > ROWS-2) ? ROWS-2 : r_top;
    ww = r_width ? r_width : 1;
    if (ww > COLS-wl) ww = COLS-wl;
    wh = r_height ? r_height : 1;
    if (wh > ROWS-wt) wh = ROWS-wt;
  endfunction

  function automatic int unsigned cell_at(int unsigned x, int unsigned y);
    return (wt+y)*COLS + wl + x;
  endfunction

  function automatic void erase_to_eol();
    if (cur_y >= wh) return;
    for (int unsigned x = cur_x; x < ww; x++) page[cell_at(x, cur_y)] = '0;
  endfunction

  // window rows shift up, last row cleared
  function automatic void scroll_window();
    n_scrolls++;
    for (int unsigned r = 0; r+1 < wh; r++)
      for (int unsigned x = 0; x < ww; x++) page[cell_at(x, r)] = page[cell_at(x, r+1)];
    cur_x = 0;
    cur_y = wh-1;
    erase_to_eol();
  endfunction

  function automatic void store_cell(logic [7:0] v);
    if (cur_x < ww && cur_y < wh) page[cell_at(cur_x, cur_y)] = v;
  endfunction

  function automatic void put_char(logic [7:0] c);
    int unsigned ts, stop;
    if (cur_x >= ww && c != CH_LF && c != CH_CR) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= wh) begin
      scroll_window();
      cur_y = wh-1;
    end
    if (c == CH_LF) begin
      cur_y++;
      if (cur_x >= ww-1) cur_x = 0;
    end else if (c == CH_CR) begin
      cur_x = 0;
    end else if (c == CH_TAB) begin
      ts = r_tab ? r_tab : 1;
      stop = (cur_x/ts + 1)*ts;
      for (int unsigned i = cur_x; i < stop; i++) put_char(CH_SPACE);
    end else if (c == CH_BS) begin
      if (cur_x > 0) cur_x--;
      else if (cur_y > 0) begin
        cur_x = ww-1;
        cur_y--;
      end
      store_cell('0);
    end else if (c == CH_VT) begin
      cur_x = 0;
      for (int i = 0; i < VT_LINES; i++) begin
        cur_y++;
        if (cur_y >= wh-1) begin
          scroll_window();
          cur_y = wh-1;
        end
      end
    end else begin
      store_cell(c - r_font[7:0]);
      cur_x++;
    end
    pause_st = ((cur_x >= ww || c == CH_LF) && cur_y >= wh-1) ? 1 : 0;
  endfunction

  function automatic cursor_rsp_t terminal_step(logic [2:0] op, logic [7:0] ch,
                                                logic [5:0] px, logic [4:0] py);
    cursor_rsp_t r;
    logic [7:0] rd;
    rd = '0;
    derive_window();
    case (op)
      OP_WRITE_CHAR: put_char(ch);
      OP_SET_CURSOR: begin
        cur_x = (px > ww) ? ww : px;
        cur_y = (py > wh) ? wh : py;
      end
      OP_CLEAR_WIN: begin
        for (int unsigned y = 0; y < wh; y++)
          for (int unsigned x = 0; x < ww; x++) page[cell_at(x, y)] = '0;
        cur_x = 0;
        cur_y = 0;
      end
      OP_CLEAR_EOL: erase_to_eol();
      OP_READ_CELL: if (px < ww && py < wh) rd = page[cell_at(px, py)];
      default: ;
    endcase
    r.col = cur_x[5:0];
    r.row = cur_y[4:0];
    r.pause = pause_st[0];
    r.rd = rd;
    return r;
  endfunction

  // one clock: check any result, note acceptances, run the watchdog
  task automatic tick(output bit item_taken, output bit cfg_taken);
    cursor_rsp_t w;
    @(posedge clk_i);
    item_taken = start && !busy;
    cfg_taken = cfg_valid_i && cfg_ready_o;
    if (result_valid_o) begin
      n_results++;
      if (expected_q.size() == 0) report("unexpected result", cursor_col_o, 0);
      else begin
        w = expected_q.pop_front();
        if (cursor_col_o !== w.col) report("cursor_col", cursor_col_o, w.col);
        if (cursor_row_o !== w.row) report("cursor_row", cursor_row_o, w.row);
        if (pause_flag_o !== w.pause) report("pause_flag", pause_flag_o, w.pause);
        if (read_data_o !== w.rd) report("read_data", read_data_o, w.rd);
      end
    end
    if (item_taken || cfg_taken || result_valid_o) idle_cycles = 0;
    else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", expected_q.size());
      $display("FAIL text_window_terminal_writer");
      $finish;
    end
  endtask

  task automatic send_request(logic [2:0] op, logic [7:0] ch, logic [5:0] px, logic [4:0] py,
                              bit typed = 0, cursor_rsp_t typed_rsp = '0);
    bit took, ctook;
    cursor_rsp_t p;
    op_i <= op;
    char_code_i <= ch;
    pos_x_i <= px;
    pos_y_i <= py;
    start <= 1'b1;
    took = 0;
    while (!took) tick(took, ctook);
    n_items++;
    if (op == OP_READ_CELL) n_reads++;
    p = terminal_step(op, ch, px, py);
    expected_q.push_back(typed ? typed_rsp : p);
    // bursts with random gaps between them
    if (--burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) tick(took, ctook);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
  endtask

  // drain every result and let the block settle before touching registers
  task automatic wait_idle();
    bit took, ctook;
    start <= 1'b0;
    tick(took, ctook);
    while (expected_q.size() != 0 || busy) tick(took, ctook);
    repeat (8) tick(took, ctook);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    bit took, ctook;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    ctook = 0;
    while (!ctook) tick(took, ctook);
    cfg_valid_i <= 1'b0;
    tick(took, ctook);
    n_cfg++;
    case (idx)
      CFG_WIN_LEFT:   r_left = data & 8'h1F;
      CFG_WIN_TOP:    r_top = data & 8'h0F;
      CFG_WIN_WIDTH:  r_width = data & 8'h3F;
      CFG_WIN_HEIGHT: r_height = data & 8'h1F;
      CFG_TAB_SIZE:   r_tab = data & 8'h3F;
      CFG_FONT_OFS:   r_font = data;
      default: ;
    endcase
    if (idx <= CFG_WIN_HEIGHT) begin
      derive_window();
      cur_x = 0;
      cur_y = 0;
    end
  endtask

  function automatic logic [7:0] pick(int lo, int hi, int full);
    case ($urandom_range(0, 3))
      0: return 8'(lo);
      1: return 8'(hi);
      default: return 8'($urandom_range(0, full));
    endcase
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 19))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_TAB;
      3, 4: return CH_BS;
      5: return CH_VT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_request();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) send_request(OP_WRITE_CHAR, random_char(), 6'($urandom), 5'($urandom));
    else if (sel < 68)
      send_request(OP_SET_CURSOR, 8'($urandom), 6'($urandom_range(0, 63)),
                   5'($urandom_range(0, 31)));
    else if (sel < 70) send_request(OP_CLEAR_WIN, 8'($urandom), 6'($urandom), 5'($urandom));
    else if (sel < 77) send_request(OP_CLEAR_EOL, 8'($urandom), 6'($urandom), 5'($urandom));
    else if (sel < 86)
      send_request(OP_READ_CELL, 8'($urandom), 6'($urandom_range(0, ww)),
                   5'($urandom_range(0, wh)));
    else if (sel < 94)
      send_request(OP_READ_CELL, 8'($urandom), 6'($urandom_range(0, 63)),
                   5'($urandom_range(0, 31)));
    else send_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                      6'($urandom), 5'($urandom));
  endtask

  stim_row_t directed[$];

  function automatic void add_row(logic [2:0] op, logic [7:0] ch, logic [5:0] x,
                                  logic [4:0] y, bit typed = 0, cursor_rsp_t rsp = '0);
    stim_row_t s;
    s.op = op; s.ch = ch; s.x = x; s.y = y; s.typed = typed; s.rsp = rsp;
    directed.push_back(s);
  endfunction

  initial begin
    bit took, ctook;
    for (int i = 0; i < COLS*ROWS; i++) page[i] = '0;
    cur_x = 0; cur_y = 0; pause_st = 0;
    r_left = RST_WIN_LEFT; r_top = RST_WIN_TOP; r_width = RST_WIN_WIDTH;
    r_height = RST_WIN_HEIGHT; r_tab = RST_TAB_SIZE; r_font = RST_FONT_OFS;
    derive_window();
    burst_left = 5;

    // hold reset low, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table: extremes, every op, control characters
    add_row(OP_READ_CELL, 8'h00, 6'd0, 5'd0, 1, '{6'd0, 5'd0, 1'b0, 8'd0});
    add_row(OP_SET_CURSOR, 8'h00, 6'd63, 5'd31, 1, '{6'd32, 5'd16, 1'b0, 8'd0});
    add_row(OP_WRITE_CHAR, 8'd65, 6'd0, 5'd0);
    add_row(OP_READ_CELL, 8'h00, 6'd0, 5'd15);
    add_row(OP_SET_CURSOR, 8'h00, 6'd0, 5'd0, 1, '{6'd0, 5'd0, 1'b0, 8'd0});
    add_row(OP_WRITE_CHAR, 8'h00, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, 8'hFF, 6'd0, 5'd0);
    add_row(OP_READ_CELL, 8'h00, 6'd1, 5'd0);
    add_row(OP_WRITE_CHAR, CH_TAB, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_BS, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_CR, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_LF, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_BS, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_VT, 6'd0, 5'd0);
    add_row(OP_CLEAR_EOL, 8'h00, 6'd0, 5'd0);
    add_row(OP_READ_CELL, 8'h00, 6'd63, 5'd31);
    add_row(OP_READ_CELL, 8'h00, 6'd31, 5'd15);
    add_row(OP_SET_CURSOR, 8'h00, 6'd31, 5'd15);
    add_row(OP_WRITE_CHAR, 8'd126, 6'd0, 5'd0);
    add_row(OP_WRITE_CHAR, CH_LF, 6'd0, 5'd0);
    add_row(OP_SPARE_LO, 8'h00, 6'd0, 5'd0);
    add_row(OP_SPARE_HI, 8'hFF, 6'd63, 5'd31);
    // the line feed on the last row left the pause flag set; clearing keeps it
    add_row(OP_CLEAR_WIN, 8'h00, 6'd0, 5'd0, 1, '{6'd0, 5'd0, 1'b1, 8'd0});
    add_row(OP_READ_CELL, 8'h00, 6'd31, 5'd15, 1, '{6'd0, 5'd0, 1'b1, 8'd0});
    foreach (directed[i])
      send_request(directed[i].op, directed[i].ch, directed[i].x, directed[i].y,
                   directed[i].typed, directed[i].rsp);

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 11; ph++) begin
      wait_idle();
      if (ph == 0) begin
        // extremes: clamped corner window, zero sizes, zero tab, top font offset
        write_reg(CFG_WIN_LEFT, 8'd31);
        write_reg(CFG_WIN_TOP, 8'd15);
        write_reg(CFG_WIN_WIDTH, 8'd0);
        write_reg(CFG_WIN_HEIGHT, 8'd0);
        write_reg(CFG_TAB_SIZE, 8'd0);
        write_reg(CFG_FONT_OFS, 8'd255);
        write_reg(CFG_SPARE_HI, 8'hFF);
      end else if (ph == 1) begin
        write_reg(CFG_WIN_LEFT, 8'd0);
        write_reg(CFG_WIN_TOP, 8'd0);
        write_reg(CFG_WIN_WIDTH, 8'd63);
        write_reg(CFG_WIN_HEIGHT, 8'd31);
        write_reg(CFG_TAB_SIZE, 8'd63);
        write_reg(CFG_FONT_OFS, 8'd0);
        write_reg(CFG_SPARE_LO, 8'h00);
      end else begin
        // mostly small windows keep scrolls short
        write_reg(CFG_WIN_LEFT, pick(0, 31, 255));
        write_reg(CFG_WIN_TOP, pick(0, 15, 255));
        write_reg(CFG_WIN_WIDTH,
                  (ph % 3 == 0) ? pick(1, 32, 255) : 8'($urandom_range(0, 9)));
        write_reg(CFG_WIN_HEIGHT,
                  (ph % 3 == 0) ? pick(1, 16, 255) : 8'($urandom_range(0, 6)));
        write_reg(CFG_TAB_SIZE, pick(1, 32, 255));
        write_reg(CFG_FONT_OFS, pick(0, 255, 255));
        if (ph % 4 == 2)
          write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
      end
      repeat (148) random_request();
    end

    // drain and settle
    wait_idle();
    repeat (40) tick(took, ctook);

    $display("covered %0d requests (%0d reads, %0d model scrolls), %0d results, %0d reg writes",
             n_items, n_reads, n_scrolls, n_results, n_cfg);
    if (errors == 0) begin
      $display("PASS text_window_terminal_writer");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL text_window_terminal_writer");
    end
    $finish;
  end
endmodule

// File: text_window_terminal_writer.f
+incdir+rtl
rtl/twtw_pkg.sv
rtl/twtw_page.sv
rtl/twtw_seq.sv
rtl/text_window_terminal_writer.sv
test/tb.sv
